[hdl/phc_pkg.sv]
// ----------------------------------------------------------------------------
// Packet header checker package
// Field positions, expected header values and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_W       = 4;
    localparam int CSUM_W      = 16;
    localparam int OUT_CSUM_W  = 13;
    localparam int CODE_W      = 4;
    localparam int HERR_W      = 3;

    localparam int FLITS_DEFAULT = 13;

    localparam logic [7:0]  VHL_EXPECT   = 8'h45;
    localparam logic [7:0]  TOS_MAX      = 8'd2;
    localparam logic [15:0] LEN_EXPECT   = 16'd52;
    localparam logic [7:0]  PROTO_EXPECT = 8'd6;

    localparam logic [IDX_W-1:0] IDX_LEN   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_ZERO  = 4'd1;
    localparam logic [IDX_W-1:0] IDX_TTL   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_DEST  = 4'd4;

    localparam logic [HERR_W-1:0] HERR_NONE  = 3'd0;
    localparam logic [HERR_W-1:0] HERR_VHL   = 3'd1;
    localparam logic [HERR_W-1:0] HERR_TOS   = 3'd2;
    localparam logic [HERR_W-1:0] HERR_LEN   = 3'd3;
    localparam logic [HERR_W-1:0] HERR_ZERO  = 3'd4;
    localparam logic [HERR_W-1:0] HERR_TTL   = 3'd5;
    localparam logic [HERR_W-1:0] HERR_PROTO = 3'd6;

    localparam logic [CODE_W-1:0] ERR_NONE     = 4'd0;
    localparam logic [CODE_W-1:0] ERR_CHECKSUM = 4'd7;
    localparam logic [CODE_W-1:0] ERR_DEST     = 4'd8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [HERR_W-1:0] herr_t;
    typedef logic [CODE_W-1:0] code_t;

endpackage

`default_nettype wire

[hdl/packet_header_checker_top.sv]
// ----------------------------------------------------------------------------
// Packet header checker
// Checks fixed-length packets word by word and reports one error code each.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------
//  flit in  | flit_valid   | flit_stall   | flit_word
//  result   | result_valid | result_stall | error_code, computed_checksum
//  config   | cfg_we       | -            | cfg_wdata (local address)
//
//  One flit per cycle while flit_stall is low; a result passes through the input
//  register, then the result register, after the last flit of a packet is taken.
//  FLITS flits make one packet and one request on the result channel.
//  Reset clears the packet state, the result valid flag and the local address.
//  result_stall holds only the last flit of a packet in the input register;
//  other flits keep moving while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_checker_top #(
    parameter int FLITS = phc_pkg::FLITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [phc_pkg::WORD_W-1:0]       cfg_wdata,
    input  wire logic                             flit_valid,
    output logic                                  flit_stall,
    input  wire logic [phc_pkg::WORD_W-1:0]       flit_word,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic [phc_pkg::CODE_W-1:0]            error_code,
    output logic [phc_pkg::OUT_CSUM_W-1:0]        computed_checksum
);
    import phc_pkg::*;

    localparam idx_t LastIdx = IDX_W'(FLITS - 1);

    word_t                   addr_reg;
    logic                    in_valid_reg;
    word_t                   in_word_reg;
    idx_t                    idx_reg;
    idx_t                    idx_next;
    logic [FLITS-1:0]        accum_reg;
    logic [FLITS-1:0]        accum_next;
    logic [CSUM_W-1:0]       rcv_csum_reg;
    logic [CSUM_W-1:0]       rcv_csum_next;
    herr_t                   herr_reg;
    herr_t                   herr_next;
    logic                    dest_bad_reg;
    logic                    dest_bad_next;
    logic                    out_valid_reg;
    code_t                   code_reg;
    code_t                   code_next;
    logic [OUT_CSUM_W-1:0]   csum_out_reg;

    logic                    is_last;
    logic                    out_free;
    logic                    advance;
    logic                    take;
    word_t                   par_word;
    logic                    word_par;
    logic [CSUM_W-1:0]       accum_ext;

    assign is_last   = (idx_reg == LastIdx);
    assign out_free  = !out_valid_reg || !result_stall;
    assign advance   = in_valid_reg && (!is_last || out_free);
    assign flit_stall = in_valid_reg && !advance;
    assign take      = flit_valid && !flit_stall;

    assign par_word  = (idx_reg == IDX_TTL) ? {in_word_reg[31:16], 16'h0000} : in_word_reg;
    assign word_par  = ^par_word;

    always_comb
    begin
        herr_next     = herr_reg;
        rcv_csum_next = rcv_csum_reg;
        dest_bad_next = dest_bad_reg;
        for (int i = 0; i < FLITS; i++)
        begin
            accum_next[i] = accum_reg[i] | (word_par && (idx_reg == IDX_W'(i)));
        end
        if (idx_reg == IDX_LEN)
        begin
            if (herr_reg == HERR_NONE)
            begin
                priority if (in_word_reg[31:24] != VHL_EXPECT)
                    herr_next = HERR_VHL;
                else if (in_word_reg[23:16] > TOS_MAX)
                    herr_next = HERR_TOS;
                else if (in_word_reg[15:0] != LEN_EXPECT)
                    herr_next = HERR_LEN;
                else
                    herr_next = herr_reg;
            end
        end
        else if (idx_reg == IDX_ZERO)
        begin
            if (herr_reg == HERR_NONE && in_word_reg != '0)
                herr_next = HERR_ZERO;
        end
        else if (idx_reg == IDX_TTL)
        begin
            if (herr_reg == HERR_NONE)
            begin
                priority if (in_word_reg[31:24] == 8'h00)
                    herr_next = HERR_TTL;
                else if (in_word_reg[23:16] != PROTO_EXPECT)
                    herr_next = HERR_PROTO;
                else
                    herr_next = herr_reg;
            end
            rcv_csum_next = in_word_reg[15:0];
        end
        else if (idx_reg == IDX_DEST)
        begin
            dest_bad_next = (in_word_reg != addr_reg);
        end
    end

    assign accum_ext = CSUM_W'(accum_next);
    assign idx_next  = is_last ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        priority if (herr_reg != HERR_NONE)
            code_next = {1'b0, herr_reg};
        else if (rcv_csum_reg != accum_ext)
            code_next = ERR_CHECKSUM;
        else if (dest_bad_reg)
            code_next = ERR_DEST;
        else
            code_next = ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            addr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= flit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            accum_reg    <= '0;
            rcv_csum_reg <= '0;
            herr_reg     <= HERR_NONE;
            dest_bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg <= idx_next;
            if (is_last)
            begin
                accum_reg    <= '0;
                rcv_csum_reg <= '0;
                herr_reg     <= HERR_NONE;
                dest_bad_reg <= 1'b0;
            end
            else
            begin
                accum_reg    <= accum_next;
                rcv_csum_reg <= rcv_csum_next;
                herr_reg     <= herr_next;
                dest_bad_reg <= dest_bad_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            code_reg     <= code_next;
            csum_out_reg <= accum_ext[OUT_CSUM_W-1:0];
        end
    end

    assign result_valid      = out_valid_reg;
    assign error_code        = code_reg;
    assign computed_checksum = csum_out_reg;

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && idx_reg == LastIdx))
        else $error("result without a last flit");

    a_index_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (idx_reg == '0 && herr_reg == HERR_NONE))
        else $error("packet state not cleared after last flit");

    a_header_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (herr_reg != HERR_NONE && !(advance && is_last)) |=> herr_reg == $past(herr_reg))
        else $error("first header error overwritten");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        flit_stall |-> (in_valid_reg && is_last && out_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

[tb/sv/phc_result_checker.sv]
// ----------------------------------------------------------------------------
// Packet header checker result checker
// Watches the configuration port and both channels, keeps its own model of
// the packet checks, and compares every result request with the oldest
// predicted verdict. Reports mismatches and hands a failure count upward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phc_result_checker #(
    parameter int FLITS = phc_pkg::FLITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  phc_pkg::word_t                     cfg_wdata,
    input  logic                               flit_valid,
    input  logic                               flit_stall,
    input  phc_pkg::word_t                     flit_word,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  phc_pkg::code_t                     error_code,
    input  logic [phc_pkg::OUT_CSUM_W-1:0]     computed_checksum,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 verdicts_checked,
    output logic [8:0]                         codes_seen
);
    import phc_pkg::*;

    typedef struct packed {
        code_t                 code;
        logic [OUT_CSUM_W-1:0] csum;
    } verdict_t;

    verdict_t              verdict_q[$];
    word_t                 node_addr;
    idx_t                  pkt_idx;
    logic [CSUM_W-1:0]     parity_bits;
    logic [CSUM_W-1:0]     rx_csum;
    herr_t                 hdr_err;
    logic                  dest_bad;
    int                    fails;
    int                    checked;
    logic [8:0]            seen;

    task automatic clear_packet();
        pkt_idx     = '0;
        parity_bits = '0;
        rx_csum     = '0;
        hdr_err     = HERR_NONE;
        dest_bad    = 1'b0;
    endtask

    task automatic absorb_flit(input word_t w);
        word_t    pw;
        verdict_t v;
        pw = w;
        if (pkt_idx == IDX_LEN) begin
            if (hdr_err == HERR_NONE) begin
                if (w[31:24] != VHL_EXPECT)
                    hdr_err = HERR_VHL;
                else if (w[23:16] > TOS_MAX)
                    hdr_err = HERR_TOS;
                else if (w[15:0] != LEN_EXPECT)
                    hdr_err = HERR_LEN;
            end
        end
        else if (pkt_idx == IDX_ZERO) begin
            if (hdr_err == HERR_NONE && w != '0)
                hdr_err = HERR_ZERO;
        end
        else if (pkt_idx == IDX_TTL) begin
            if (hdr_err == HERR_NONE) begin
                if (w[31:24] == 8'd0)
                    hdr_err = HERR_TTL;
                else if (w[23:16] != PROTO_EXPECT)
                    hdr_err = HERR_PROTO;
            end
            rx_csum = w[15:0];
            pw = {w[31:16], 16'h0000};
        end
        else if (pkt_idx == IDX_DEST) begin
            dest_bad = (w != node_addr);
        end
        parity_bits[pkt_idx] = parity_bits[pkt_idx] | (^pw);

        if (int'(pkt_idx) + 1 < FLITS) begin
            pkt_idx = pkt_idx + 1'b1;
        end
        else begin
            if (hdr_err != HERR_NONE)
                v.code = {1'b0, hdr_err};
            else if (rx_csum != parity_bits)
                v.code = ERR_CHECKSUM;
            else if (dest_bad)
                v.code = ERR_DEST;
            else
                v.code = ERR_NONE;
            v.csum = parity_bits[OUT_CSUM_W-1:0];
            verdict_q.push_back(v);
            clear_packet();
        end
    endtask

    task automatic check_verdict();
        verdict_t v;
        if (verdict_q.size() == 0) begin
            if (fails < 10)
                $display("[%0t] unexpected result: error_code %0d computed_checksum %h",
                         $realtime, error_code, computed_checksum);
            fails++;
        end
        else begin
            v = verdict_q.pop_front();
            if (v.code !== error_code || v.csum !== computed_checksum) begin
                if (fails < 10)
                    $display("[%0t] mismatch: error_code exp %0d got %0d, %s %h got %h",
                             $realtime, v.code, error_code, "computed_checksum exp",
                             v.csum, computed_checksum);
                fails++;
            end
        end
        if (error_code <= 4'd8)
            seen[error_code] = 1'b1;
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            verdict_q.delete();
            node_addr = '0;
            clear_packet();
            fails   = 0;
            checked = 0;
            seen    = '0;
            fail_count       <= 0;
            pending          <= 0;
            verdicts_checked <= 0;
            codes_seen       <= '0;
        end
        else begin
            if (cfg_we)
                node_addr = cfg_wdata;
            if (flit_valid && !flit_stall)
                absorb_flit(flit_word);
            if (result_valid && !result_stall)
                check_verdict();
            fail_count       <= fails;
            pending          <= verdict_q.size();
            verdicts_checked <= checked;
            codes_seen       <= seen;
        end
    end

endmodule

[tb/sv/packet_header_checker_top_tb.sv]
// ----------------------------------------------------------------------------
// Packet header checker testbench
// Sends whole packets, mostly well formed with one or more injected header,
// checksum or destination faults, plus pure noise, under random gaps and
// result back-pressure. The local address is rewritten between phases while
// the block is idle. The result checker predicts and compares each verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_checker_top_tb;
    import phc_pkg::*;

    localparam int FLITS       = FLITS_DEFAULT;
    localparam int PACKETS     = 100;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {
        PK_GOOD, PK_VHL, PK_TOS, PK_LEN, PK_ZERO, PK_TTL, PK_PROTO,
        PK_CSUM, PK_DEST, PK_MULTI, PK_NOISE
    } pkt_kind_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    word_t                  cfg_wdata = '0;
    logic                   flit_valid = 1'b0;
    logic                   flit_stall;
    word_t                  flit_word = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    code_t                  error_code;
    logic [OUT_CSUM_W-1:0]  computed_checksum;

    int                     fail_count;
    int                     pending;
    int                     verdicts_checked;
    logic [8:0]             codes_seen;

    logic                   quiet = 1'b0;
    int                     cycles = 0;
    int                     flits_sent = 0;
    int                     addr_writes = 0;
    word_t                  node_addr = '0;
    logic                   spoil_csum;
    word_t                  pkt [FLITS];

    packet_header_checker_top #(
        .FLITS(FLITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .flit_valid        (flit_valid),
        .flit_stall        (flit_stall),
        .flit_word         (flit_word),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .error_code        (error_code),
        .computed_checksum (computed_checksum)
    );

    phc_result_checker #(
        .FLITS(FLITS)
    ) verdict_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .flit_valid        (flit_valid),
        .flit_stall        (flit_stall),
        .flit_word         (flit_word),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .error_code        (error_code),
        .computed_checksum (computed_checksum),
        .fail_count        (fail_count),
        .pending           (pending),
        .verdicts_checked  (verdicts_checked),
        .codes_seen        (codes_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL packet_header_checker_top");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_stall <= !quiet && ($urandom_range(99) < 35);
    end

    task automatic send_flit(input word_t w);
        while (!quiet && $urandom_range(99) < 35) begin
            flit_valid <= 1'b0;
            @(posedge clk);
        end
        flit_valid <= 1'b1;
        flit_word  <= w;
        @(posedge clk);
        while (flit_stall)
            @(posedge clk);
        flits_sent++;
    endtask

    task automatic send_packet();
        int k;
        for (k = 0; k < FLITS; k++)
            send_flit(pkt[k]);
    endtask

    // hold off until every verdict is back and the pipeline is empty
    task automatic drain();
        flit_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_addr(input word_t a);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_addr = a;
        addr_writes++;
    endtask

    task automatic base_packet();
        int k;
        pkt[0] = {VHL_EXPECT, 8'($urandom_range(TOS_MAX)), LEN_EXPECT};
        pkt[1] = '0;
        pkt[2] = {8'($urandom_range(255, 1)), PROTO_EXPECT, 16'h0000};
        for (k = 3; k < FLITS; k++)
            pkt[k] = $urandom;
        pkt[IDX_DEST] = node_addr;
        spoil_csum = 1'b0;
    endtask

    task automatic apply_fault(input pkt_kind_e kind);
        logic [7:0]  b;
        logic [15:0] h;
        case (kind)
            PK_VHL: begin
                do b = 8'($urandom); while (b == VHL_EXPECT);
                pkt[0][31:24] = b;
            end
            PK_TOS:   pkt[0][23:16] = 8'($urandom_range(255, int'(TOS_MAX) + 1));
            PK_LEN: begin
                do h = 16'($urandom); while (h == LEN_EXPECT);
                pkt[0][15:0] = h;
            end
            PK_ZERO: begin
                if ($urandom_range(1))
                    pkt[1] = 32'h1 << $urandom_range(31);
                else
                    pkt[1] = $urandom | 32'h1;
            end
            PK_TTL:   pkt[2][31:24] = 8'd0;
            PK_PROTO: begin
                do b = 8'($urandom); while (b == PROTO_EXPECT);
                pkt[2][23:16] = b;
            end
            PK_CSUM:  spoil_csum = 1'b1;
            PK_DEST: begin
                if ($urandom_range(1))
                    pkt[IDX_DEST] = node_addr ^ (32'h1 << $urandom_range(31));
                else
                    pkt[IDX_DEST] = node_addr ^ ($urandom | 32'h1);
            end
            default: ;
        endcase
    endtask

    task automatic seal_packet();
        logic [15:0] csum;
        int          k;
        csum = '0;
        for (k = 0; k < FLITS; k++)
            csum[k] = (k == 2) ? ^pkt[2][31:16] : ^pkt[k];
        if (spoil_csum) begin
            if ($urandom_range(1))
                csum = csum ^ (16'h1 << $urandom_range(15));
            else
                csum = csum ^ (16'($urandom) | 16'h8000);
        end
        pkt[2][15:0] = csum;
    endtask

    task automatic random_packet();
        int        r;
        int        k;
        pkt_kind_e kind;
        r = $urandom_range(99);
        if (r < 25)
            kind = PK_GOOD;
        else if (r < 33)
            kind = PK_NOISE;
        else if (r < 40)
            kind = PK_MULTI;
        else
            kind = pkt_kind_e'($urandom_range(int'(PK_DEST), int'(PK_VHL)));

        if (kind == PK_NOISE) begin
            for (k = 0; k < FLITS; k++)
                pkt[k] = $urandom;
            return;
        end
        base_packet();
        if (kind == PK_MULTI) begin
            repeat ($urandom_range(3, 2))
                apply_fault(pkt_kind_e'($urandom_range(int'(PK_DEST), int'(PK_VHL))));
        end
        else begin
            apply_fault(kind);
        end
        seal_packet();
    endtask

    initial
    begin
        int    p;
        int    k;
        int    next_cfg;
        word_t a;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // well-formed packet at the field boundaries, destination at reset address
        base_packet();
        pkt[0][23:16] = TOS_MAX;
        pkt[2][31:24] = 8'hFF;
        for (k = 3; k < FLITS; k++)
            pkt[k] = (k == IDX_DEST) ? node_addr : 32'hFFFF_FFFF;
        seal_packet();
        send_packet();

        // all-ones packet
        for (k = 0; k < FLITS; k++)
            pkt[k] = 32'hFFFF_FFFF;
        send_packet();

        drain();
        set_addr(32'hFFFF_FFFF);

        next_cfg = 8;
        for (p = 2; p < PACKETS; p++) begin
            quiet <= (p >= 35 && p < 55);
            if (p == next_cfg) begin
                drain();
                case (addr_writes % 5)
                    0:       a = '0;
                    1:       a = 32'h8000_0000;
                    2:       a = 32'hFFFF_FFFF;
                    default: a = $urandom;
                endcase
                set_addr(a);
                next_cfg = p + $urandom_range(25, 8);
            end
            random_packet();
            send_packet();
        end

        quiet <= 1'b0;
        drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d packets (%0d flits) over %0d local address settings.",
                 flits_sent / FLITS, flits_sent, addr_writes + 1);
        $display("Compared %0d verdicts; error codes returned (bit n = code n): %b",
                 verdicts_checked, codes_seen);
        if (fail_count == 0)
            $display("PASS packet_header_checker_top");
        else
            $display("FAIL packet_header_checker_top");
        $finish;
    end

endmodule
